[hw/rtl/xs128rg_pkg.sv]
package xs128rg_pkg;

    // Width of one generator word and of the range bounds.
    localparam int WORD_W = 32;

    // Width of a drawn value before reduction.
    localparam int VALUE_W = 31;

    // Canonical seeds of the four state words.
    localparam logic [WORD_W-1:0] SEED_A = 32'h075B_CD15;
    localparam logic [WORD_W-1:0] SEED_B = 32'h159A_55E5;
    localparam logic [WORD_W-1:0] SEED_C = 32'h1F12_3BB5;
    localparam logic [WORD_W-1:0] SEED_D = 32'h0549_1333;

    // Shift amounts of the generator step.
    localparam int SHIFT_1 = 11;
    localparam int SHIFT_2 = 8;
    localparam int SHIFT_3 = 19;

    // Request commands.
    typedef enum logic {
        CMD_DRAW   = 1'b0,
        CMD_RESEED = 1'b1
    } t_cmd;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ADV  = 6'b000010,
        S_SPAN = 6'b000100,
        S_MAG  = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    // One restoring division step per bit of the drawn value.
    localparam int DIV_STEPS = VALUE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // One generator step: returns the new fourth word.
    function automatic logic [WORD_W-1:0] xs_next(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] t;
        t = a ^ (a << SHIFT_1);
        return t ^ (t >> SHIFT_2) ^ d ^ (d >> SHIFT_3);
    endfunction

endpackage

[hw/rtl/xs128rg_ifs.sv]
// Request channel: a draw or a reseed.
interface xs128rg_req_if;
    import xs128rg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [WORD_W-1:0]        seed_value;
    logic signed [WORD_W-1:0] range_min;
    logic signed [WORD_W-1:0] range_max;

    modport source (output valid, command, seed_value, range_min, range_max,
                    input ready);
    modport sink   (input valid, command, seed_value, range_min, range_max,
                    output ready);
endinterface

// Result channel: one drawn number per draw request.
interface xs128rg_rsp_if;
    import xs128rg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] random_value;

    modport source (output valid, random_value, input ready);
    modport sink   (input valid, random_value, output ready);
endinterface

[hw/rtl/xorshift128_range_generator.sv]
// A draw request runs through the states ADV, SPAN and MAG, the 31 steps of the
// restoring divider on the shared adder, and FIN, where the result is loaded.
// No new request is taken until a draw has finished; a reseed gives no result.
// A finished result waits in an output register while the next request runs.
// Reset (synchronous, active low) loads the canonical seeds and empties the
// output register.
module xorshift128_range_generator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    xs128rg_req_if.sink       i_req,
    xs128rg_rsp_if.source     o_rsp
);
    import xs128rg_pkg::*;

    t_state                   r_state, n_state;
    logic [WORD_W-1:0]        r_word_a, r_word_b, r_word_c, r_word_d;
    logic signed [WORD_W-1:0] r_lo, r_hi;
    logic [WORD_W-1:0]        r_acc;
    logic [WORD_W-1:0]        r_mag;
    logic [VALUE_W-1:0]       r_dvd;
    logic [WORD_W-1:0]        r_rem;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_out;

    logic                     req_acc;
    logic                     out_load;
    logic [WORD_W-1:0]        new_d;
    logic [WORD_W-1:0]        shifted;
    logic [WORD_W:0]          u_a, u_b, u_sum;
    logic                     u_cin;

    // Requests are taken only while the sequencer is idle.
    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;

    // The result is loaded once the output register is free or being emptied.
    assign out_load = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.random_value = r_out;

    // Generator step and the partial remainder shifted by one dividend bit.
    assign new_d   = xs_next(r_word_a, r_word_d);
    assign shifted = {r_rem[WORD_W-2:0], r_dvd[VALUE_W-1]};

    // Operand selection of the shared 33-bit adder.
    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_cin = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                u_a   = '0;
            end
            S_ADV: begin
                // Difference of the bounds.
                u_a   = {1'b0, r_hi};
                u_b   = {1'b0, ~r_lo};
                u_cin = 1'b1;
            end
            S_SPAN: begin
                // Span is the difference plus one, wrapped to 32 bits.
                u_a   = {1'b0, r_acc};
                u_cin = 1'b1;
            end
            S_MAG: begin
                // Magnitude of the span read as a signed number.
                u_a   = {1'b0, (r_acc[WORD_W-1] ? ~r_acc : r_acc)};
                u_cin = r_acc[WORD_W-1];
            end
            S_DIV: begin
                // Trial subtraction; the carry out means no borrow.
                u_a   = {1'b0, shifted};
                u_b   = {1'b0, ~r_mag};
                u_cin = 1'b1;
            end
            S_FIN: begin
                // Remainder plus the lower bound, wrapped to 32 bits.
                u_a   = {1'b0, r_rem};
                u_b   = {1'b0, r_lo};
            end
            default: begin
                u_a   = '0;
            end
        endcase
    end

    assign u_sum = u_a + u_b + {{WORD_W{1'b0}}, u_cin};

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc && (t_cmd'(i_req.command) == CMD_DRAW)) begin
                    n_state = S_ADV;
                end
            end
            S_ADV:  n_state = S_SPAN;
            S_SPAN: n_state = S_MAG;
            S_MAG:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, generator words and the output flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_word_a    <= SEED_A;
            r_word_b    <= SEED_B;
            r_word_c    <= SEED_C;
            r_word_d    <= SEED_D;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (req_acc && (t_cmd'(i_req.command) == CMD_RESEED)) begin
                r_word_a <= SEED_A;
                r_word_b <= SEED_B;
                r_word_c <= SEED_C;
                r_word_d <= i_req.seed_value;
            end else if (r_state == S_ADV) begin
                r_word_a <= r_word_b;
                r_word_b <= r_word_c;
                r_word_c <= r_word_d;
                r_word_d <= new_d;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers; these need no reset.
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_lo <= i_req.range_min;
            r_hi <= i_req.range_max;
        end
        unique case (r_state)
            S_IDLE: begin
                r_cnt <= r_cnt;
            end
            S_ADV: begin
                r_acc <= u_sum[WORD_W-1:0];
                r_dvd <= new_d[VALUE_W-1:0];
            end
            S_SPAN: begin
                r_acc <= u_sum[WORD_W-1:0];
            end
            S_MAG: begin
                r_mag <= u_sum[WORD_W-1:0];
                r_rem <= '0;
                r_cnt <= CNT_W'(DIV_STEPS - 1);
            end
            S_DIV: begin
                // A zero magnitude always subtracts nothing, so the value
                // passes through unreduced.
                r_rem <= u_sum[WORD_W] ? u_sum[WORD_W-1:0] : shifted;
                r_dvd <= {r_dvd[VALUE_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            S_FIN: begin
                if (out_load) begin
                    r_out <= u_sum[WORD_W-1:0];
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The partial remainder stays below a non-zero magnitude.
    a_rem_below_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_mag != '0) |-> (r_rem < r_mag))
        else $error("partial remainder not below the magnitude");

    // The remainder never reaches the top bit while dividing.
    a_rem_top_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !r_rem[WORD_W-1])
        else $error("partial remainder overflow");

    // The divider always starts with a full count of steps.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAG) |=> (r_state == S_DIV && r_cnt == CNT_W'(DIV_STEPS - 1)))
        else $error("divider started with a wrong count");

    // A finished draw is presented on the result channel.
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished draw not presented");

    // A reseed request restores the canonical first word.
    a_reseed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.command) |=> (r_word_a == SEED_A && r_state == S_IDLE))
        else $error("reseed did not reload the first word");
`endif

endmodule

[test/xorshift128_range_generator_tb.sv]
`timescale 1ns / 100ps

module xorshift128_range_generator_tb;
    import xs128rg_pkg::*;

    // One request as the sender offers it.
    typedef struct {
        t_cmd                     cmd;
        logic [WORD_W-1:0]        seed;
        logic signed [WORD_W-1:0] lo;
        logic signed [WORD_W-1:0] hi;
    } t_gen_request;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 50;

    logic i_clk;
    logic i_rst_n;

    xs128rg_req_if req_ch ();
    xs128rg_rsp_if rsp_ch ();

    xorshift128_range_generator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Requests waiting to be offered and predicted numbers waiting to be received.
    t_gen_request      pending_requests[$];
    logic [WORD_W-1:0] expected_numbers[$];

    // Predicted generator words.
    logic [WORD_W-1:0] gen_a, gen_b, gen_c, gen_d;

    int n_errors     = 0;
    int n_draws      = 0;
    int n_reseeds    = 0;
    int n_checked    = 0;
    int n_holds      = 0;
    int reqs_taken   = 0;
    int reqs_queued  = 0;

    // Sender and receiver pacing.
    t_gen_request cur_req;
    bit           offering   = 1'b0;
    bit           send_burst = 1'b0;
    int           send_gap   = 0;
    bit           take_burst = 1'b0;
    int           take_wait  = 0;
    int           hold_left  = 0;

    // Clock, reset and known values on every input from the start.
    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.command     = CMD_DRAW;
        req_ch.seed_value  = '0;
        req_ch.range_min   = '0;
        req_ch.range_max   = '0;
        rsp_ch.ready       = 1'b0;
        fork
            forever #5 i_clk = ~i_clk;
            begin
                repeat (2) @(posedge i_clk);
                i_rst_n <= 1'b1;
            end
        join_none
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        n_errors++;
    endtask

    // Advance the predicted generator for one accepted request.
    task automatic predict_number(input t_gen_request rq);
        logic [WORD_W-1:0] t, w, raw, span, mag, rem;
        if (rq.cmd == CMD_RESEED) begin
            gen_a = SEED_A;
            gen_b = SEED_B;
            gen_c = SEED_C;
            gen_d = rq.seed;
            n_reseeds++;
        end else begin
            t     = gen_a ^ (gen_a << SHIFT_1);
            w     = gen_d;
            gen_a = gen_b;
            gen_b = gen_c;
            gen_c = w;
            gen_d = t ^ (t >> SHIFT_2) ^ w ^ (w >> SHIFT_3);
            raw   = gen_d & 32'h7FFF_FFFF;
            // The span wraps to 32 bits; its signed magnitude is the modulus.
            span  = rq.hi - rq.lo + 32'd1;
            mag   = span[WORD_W-1] ? (32'd0 - span) : span;
            rem   = (mag != 0) ? (raw % mag) : raw;
            expected_numbers.push_back(rem + rq.lo);
            n_draws++;
        end
    endtask

    task automatic queue_request(input t_cmd cmd, input logic [WORD_W-1:0] seed,
                                 input logic [WORD_W-1:0] lo,
                                 input logic [WORD_W-1:0] hi);
        t_gen_request rq;
        rq.cmd  = cmd;
        rq.seed = seed;
        rq.lo   = lo;
        rq.hi   = hi;
        pending_requests.push_back(rq);
        reqs_queued++;
    endtask

    // A word biased towards the boundaries of the signed range.
    function automatic logic [WORD_W-1:0] boundary_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4: return 32'($urandom_range(0, 15));
            5: return 32'h8000_0000 + 32'($urandom_range(0, 15));
            default: return $urandom();
        endcase
    endfunction

    // Sender: offers queued requests with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
            send_gap = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predict_number(cur_req);
                reqs_taken <= reqs_taken + 1;
                offering = 1'b0;
                if ($urandom_range(0, 39) == 0) begin
                    send_burst = !send_burst;
                end
                send_gap = send_burst ? 0 : $urandom_range(0, 16);
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_requests.size() != 0) begin
                    cur_req  = pending_requests.pop_front();
                    offering = 1'b1;
                end
            end
            req_ch.valid      <= offering;
            req_ch.command    <= cur_req.cmd;
            req_ch.seed_value <= cur_req.seed;
            req_ch.range_min  <= cur_req.lo;
            req_ch.range_max  <= cur_req.hi;
        end
    end

    // Long receiver hold-offs, so that the block fills up and stalls requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left == 0 && n_holds < 2
                     && reqs_taken >= (n_holds == 0 ? 400 : 1200)) begin
            hold_left <= HOLD_CYCLES;
            n_holds   <= n_holds + 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks each drawn number against the oldest prediction.
    always @(posedge i_clk) begin
        logic [WORD_W-1:0] want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            take_wait = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_numbers.size() == 0) begin
                    report_mismatch($sformatf("unexpected number %0d",
                                              rsp_ch.random_value));
                end else begin
                    want = expected_numbers.pop_front();
                    n_checked++;
                    if (rsp_ch.random_value !== want) begin
                        report_mismatch($sformatf("random_value %0d, predicted %0d",
                                                  rsp_ch.random_value,
                                                  $signed(want)));
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    take_burst = !take_burst;
                end
                take_wait = take_burst ? 0 : $urandom_range(0, 16);
            end else if (take_wait > 0) begin
                take_wait--;
            end
            rsp_ch.ready <= (take_wait == 0) && (hold_left == 0);
        end
    end

    // Stimulus and end of run.
    initial begin
        int               kind;
        logic [WORD_W-1:0] lo, hi;
        t_cmd             cmd;

        gen_a = SEED_A;
        gen_b = SEED_B;
        gen_c = SEED_C;
        gen_d = SEED_D;

        // Directed part: boundary ranges, wrapped spans and reseeds.
        queue_request(CMD_DRAW,   32'h0,         32'h0,         32'h0);
        queue_request(CMD_DRAW,   32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(CMD_DRAW,   32'h0,         32'h8000_0000, 32'h8000_0000);
        queue_request(CMD_DRAW,   32'h0,         32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_request(CMD_DRAW,   32'h0,         32'h0,         32'h7FFF_FFFF);
        queue_request(CMD_DRAW,   32'h0,         32'hFFFF_FFFF, 32'h7FFF_FFFE);
        queue_request(CMD_DRAW,   32'h0,         32'h7FFF_FFFF, 32'h8000_0000);
        queue_request(CMD_DRAW,   32'h0,         32'd10,        -32'sd10);
        queue_request(CMD_DRAW,   32'h0,         32'h7FFF_FFF0, 32'h7FFF_FFFF);
        queue_request(CMD_DRAW,   32'h0,         32'd0,         32'd9);
        queue_request(CMD_DRAW,   32'h0,         -32'sd5,       32'd5);
        queue_request(CMD_DRAW,   32'h0,         32'd1,         32'd6);
        queue_request(CMD_RESEED, 32'h0,         32'hFFFF_FFFF, 32'h0);
        queue_request(CMD_DRAW,   32'h0,         32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(CMD_DRAW,   32'h0,         32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(CMD_RESEED, 32'hFFFF_FFFF, 32'h0,         32'hFFFF_FFFF);
        queue_request(CMD_RESEED, 32'h1234_5678, 32'h0,         32'h0);
        queue_request(CMD_DRAW,   32'h0,         -32'sd100,     -32'sd1);
        queue_request(CMD_DRAW,   32'h0,         32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(CMD_RESEED, SEED_D,        32'h0,         32'h0);
        queue_request(CMD_DRAW,   32'h0,         32'h8000_0000, 32'h8000_0001);

        // Random part: mostly draws over ranges of every shape, some reseeds.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            kind = $urandom_range(0, 9);
            cmd  = CMD_DRAW;
            lo   = boundary_word();
            hi   = boundary_word();
            case (kind)
                0: cmd = CMD_RESEED;
                1, 2, 3, 4: begin
                    if ($urandom_range(0, 1)) begin
                        lo = 32'($urandom_range(0, 200)) - 32'd100;
                    end
                    hi = lo + 32'($urandom_range(0, 100));
                end
                5, 6: begin
                    if ($signed(lo) > $signed(hi)) begin
                        {lo, hi} = {hi, lo};
                    end
                end
                9: begin
                    lo = $urandom();
                    hi = lo + ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF);
                end
                default: ;
            endcase
            queue_request(cmd, boundary_word(), lo, hi);
        end

        // Drain: every request taken, every number seen, then a quiet spell.
        while (reqs_taken != reqs_queued) @(posedge i_clk);
        while (expected_numbers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d draws and %0d reseeds, %0d numbers checked.",
                 n_draws, n_reseeds, n_checked);
        $display("Receiver held off %0d times; %0d mismatches.", n_holds, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog in case the block stops answering.
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
